[design/r2n_pkg.sv]
// Shared types and constants for the RGB to NV12 converter.
package r2n_pkg;

  // Frame size limits and derived widths
  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;
  localparam int CFG_W      = 13;
  localparam int SIZE_W     = CFG_W + 1;
  localparam int COL_W      = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int ROW_W      = (MAX_HEIGHT > 2) ? $clog2(MAX_HEIGHT) : 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);
  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(1920);
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(1080);

  // BT.601 integer weights
  localparam int Y_R   = 66;
  localparam int Y_G   = 129;
  localparam int Y_B   = 25;
  localparam int ROUND = 128;
  localparam int Y_OFS = 16;
  localparam int CB_R  = 38;
  localparam int CB_G  = 74;
  localparam int CB_B  = 112;
  localparam int CR_R  = 112;
  localparam int CR_G  = 94;
  localparam int CR_B  = 18;
  // rounding plus 128 << 8 keeps the chroma sums positive
  localparam int C_OFS = ROUND + (128 << 8);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] cb_value;
    logic [7:0] cr_value;
    logic       frame_done;
  } result_t;

endpackage

[design/rgb_to_nv12_converter_core.sv]
// RGB to NV12 converter: BT.601 luma per pixel, 2x2 averaged chroma.
// Pipeline: an accepted pixel request is held in the input stage register, then
//   in the result register. The line store has one read and one write port.
// Throughput: one pixel per clock while the result side is not stalled.
// Reset (rst, synchronous): counters to frame start, size 1920x1080, pipeline empty.
// The line store is not cleared; every entry is written by an even row before use.
module rgb_to_nv12_converter_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pixel_valid,
  output logic                          pixel_ready,
  input  r2n_pkg::pixel_t               pixel,
  output logic                          result_valid,
  input  logic                          result_ready,
  output r2n_pkg::result_t              result,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [r2n_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [r2n_pkg::CFG_W-1:0]     cfg_data
);

  localparam int CW = r2n_pkg::COL_W;
  localparam int RW = r2n_pkg::ROW_W;
  localparam int AW = r2n_pkg::LINE_AW;

  // ---------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------
  logic [r2n_pkg::CFG_W-1:0] frame_width;
  logic [r2n_pkg::CFG_W-1:0] frame_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= r2n_pkg::FRAME_WIDTH_RST;
      frame_height <= r2n_pkg::FRAME_HEIGHT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        r2n_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        r2n_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // Last column / row index: zero acts as one, oversize clamps to the max.
  logic [CW-1:0] last_col_idx;
  logic [RW-1:0] last_row_idx;

  always_comb begin
    if (frame_width == '0) begin
      last_col_idx = '0;
    end else if ({1'b0, frame_width} > r2n_pkg::SIZE_W'(r2n_pkg::MAX_WIDTH)) begin
      last_col_idx = CW'(r2n_pkg::MAX_WIDTH - 1);
    end else begin
      last_col_idx = CW'(frame_width - 1'b1);
    end
    if (frame_height == '0) begin
      last_row_idx = '0;
    end else if ({1'b0, frame_height} > r2n_pkg::SIZE_W'(r2n_pkg::MAX_HEIGHT)) begin
      last_row_idx = RW'(r2n_pkg::MAX_HEIGHT - 1);
    end else begin
      last_row_idx = RW'(frame_height - 1'b1);
    end
  end

  // ---------------------------------------------------------------
  // Handshake and raster position
  // ---------------------------------------------------------------
  logic a_valid;
  logic a_advance;
  logic pixel_accept;

  assign a_advance    = a_valid && (!result_valid || result_ready);
  assign pixel_ready  = !a_valid || a_advance;
  assign pixel_accept = pixel_valid && pixel_ready;

  logic [CW-1:0] column_count, column_count_next;
  logic [RW-1:0] row_count, row_count_next;
  logic          last_col, last_row;

  assign last_col = column_count >= last_col_idx;
  assign last_row = row_count >= last_row_idx;

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (last_col) begin
      column_count_next = '0;
      row_count_next    = last_row ? '0 : row_count + 1'b1;
    end else begin
      column_count_next = column_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_accept) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

  // ---------------------------------------------------------------
  // Input stage: pixel plus its role in the 2x2 block
  // ---------------------------------------------------------------
  r2n_pkg::pixel_t a_px;
  logic            a_left;    // even column, holds its chroma for the odd one
  logic            a_col_odd;
  logic            a_store;   // even row, pair sum goes to the line store
  logic            a_row_odd;
  logic            a_done;
  logic [AW-1:0]   a_idx;
  logic [AW-1:0]   rd_idx;

  assign rd_idx = AW'(column_count >> 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (pixel_accept) begin
      a_valid <= 1'b1;
    end else if (a_advance) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      a_px      <= pixel;
      a_left    <= !column_count[0] && !last_col;
      a_col_odd <= column_count[0];
      a_store   <= !row_count[0] && !last_row;
      a_row_odd <= row_count[0];
      a_done    <= last_col && last_row;
      a_idx     <= rd_idx;
    end
  end

  // ---------------------------------------------------------------
  // Color conversion (constant multiplies, floor shift by 8)
  // ---------------------------------------------------------------
  logic [16:0] y_sum, cb_sum, cr_sum;
  logic [7:0]  luma, cb_pix, cr_pix;

  assign y_sum  = 17'(r2n_pkg::Y_R) * {9'd0, a_px.red}
                + 17'(r2n_pkg::Y_G) * {9'd0, a_px.green}
                + 17'(r2n_pkg::Y_B) * {9'd0, a_px.blue}
                + 17'(r2n_pkg::ROUND);
  assign cb_sum = 17'(r2n_pkg::C_OFS)
                + 17'(r2n_pkg::CB_B) * {9'd0, a_px.blue}
                - 17'(r2n_pkg::CB_R) * {9'd0, a_px.red}
                - 17'(r2n_pkg::CB_G) * {9'd0, a_px.green};
  assign cr_sum = 17'(r2n_pkg::C_OFS)
                + 17'(r2n_pkg::CR_R) * {9'd0, a_px.red}
                - 17'(r2n_pkg::CR_G) * {9'd0, a_px.green}
                - 17'(r2n_pkg::CR_B) * {9'd0, a_px.blue};

  assign luma   = y_sum[15:8] + 8'(r2n_pkg::Y_OFS);
  assign cb_pix = cb_sum[15:8];
  assign cr_pix = cr_sum[15:8];

  // ---------------------------------------------------------------
  // Horizontal pair sums; an even last column counts twice
  // ---------------------------------------------------------------
  logic [15:0] left_pixel_chroma;
  logic [8:0]  pair_cb, pair_cr;

  always_comb begin
    if (a_col_odd) begin
      pair_cb = {1'b0, left_pixel_chroma[15:8]} + {1'b0, cb_pix};
      pair_cr = {1'b0, left_pixel_chroma[7:0]} + {1'b0, cr_pix};
    end else begin
      pair_cb = {cb_pix, 1'b0};
      pair_cr = {cr_pix, 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel_chroma <= '0;
    end else if (a_advance && a_left) begin
      left_pixel_chroma <= {cb_pix, cr_pix};
    end
  end

  // ---------------------------------------------------------------
  // Line store of even-row pair sums. Read at request accept; a write
  // leaving the input stage on the same edge is forwarded.
  // ---------------------------------------------------------------
  logic [17:0] line_mem [r2n_pkg::LINE_DEPTH];
  logic [17:0] line_rd;
  logic [17:0] line_wr;
  logic        line_we;
  logic        fwd_hit;
  logic [17:0] fwd_data;
  logic [17:0] line_sum;

  assign line_wr  = {pair_cb, pair_cr};
  assign line_we  = a_advance && !a_left && a_store;
  assign line_sum = fwd_hit ? fwd_data : line_rd;

  always_ff @(posedge clk) begin
    if (line_we) begin
      line_mem[a_idx] <= line_wr;
    end
    if (pixel_accept) begin
      line_rd <= line_mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      fwd_hit  <= line_we && (a_idx == rd_idx);
      fwd_data <= line_wr;
    end
  end

  // ---------------------------------------------------------------
  // Vertical block sums; an even last row counts twice
  // ---------------------------------------------------------------
  logic [9:0] block_cb, block_cr;
  logic       block_close;

  assign block_close = !a_left && !a_store;

  always_comb begin
    if (a_row_odd) begin
      block_cb = {1'b0, line_sum[17:9]} + {1'b0, pair_cb};
      block_cr = {1'b0, line_sum[8:0]} + {1'b0, pair_cr};
    end else begin
      block_cb = {pair_cb, 1'b0};
      block_cr = {pair_cr, 1'b0};
    end
  end

  // ---------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (a_advance) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (a_advance) begin
      result.luma         <= luma;
      result.chroma_valid <= block_close;
      result.cb_value     <= block_close ? block_cb[9:2] : 8'd0;
      result.cr_value     <= block_close ? block_cr[9:2] : 8'd0;
      result.frame_done   <= a_done;
    end
  end

  // ---------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------
  a_accept_fills_stage: assert property (@(posedge clk) disable iff (rst)
    pixel_accept |=> a_valid)
    else $error("accepted pixel request did not reach the input stage");

  a_empty_takes_pixel: assert property (@(posedge clk) disable iff (rst)
    !a_valid |-> pixel_ready)
    else $error("input stage empty but pixel request refused");

  a_done_closes_block: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.frame_done |-> result.chroma_valid)
    else $error("last pixel of frame did not close a chroma block");

  a_no_chroma_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result.chroma_valid |->
      result.cb_value == 8'd0 && result.cr_value == 8'd0)
    else $error("chroma output nonzero outside a closed block");

  a_luma_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> result.luma >= 8'd16 && result.luma <= 8'd235)
    else $error("luma out of studio range");

endmodule

[bench/rgb_to_nv12_converter_core_tb.sv]
// Self-checking testbench for the RGB to NV12 converter core.
module rgb_to_nv12_converter_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes with no register behind them; writes there must be ignored
  localparam logic [r2n_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = r2n_pkg::CFG_IDX_W'(2);
  localparam logic [r2n_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = r2n_pkg::CFG_IDX_W'(3);

  // Directed requests, then roughly this many random ones
  localparam int DIRECTED_PIXELS = 20;
  localparam int RANDOM_PIXELS   = 1050;

  // Predicts luma, 2x2 chroma and frame end for each accepted pixel,
  // and holds the predicted results until the core delivers them.
  class nv12_predictor;
    logic [r2n_pkg::CFG_W-1:0] width_reg;
    logic [r2n_pkg::CFG_W-1:0] height_reg;
    int                        col_cnt;
    int                        row_cnt;
    logic [7:0]                left_cb;
    logic [7:0]                left_cr;
    // Cb pair sum in 17:9, Cr pair sum in 8:0, stored by even rows
    logic [17:0]               pair_sums [r2n_pkg::LINE_DEPTH];
    r2n_pkg::result_t          pending_yuv [$];
    int                        mismatches;

    function new();
      width_reg  = r2n_pkg::FRAME_WIDTH_RST;
      height_reg = r2n_pkg::FRAME_HEIGHT_RST;
      col_cnt    = 0;
      row_cnt    = 0;
      left_cb    = '0;
      left_cr    = '0;
      mismatches = 0;
    endfunction

    // zero acts as one, anything past the maximum acts as the maximum
    static function int clamp_size(int v, int lim);
      if (v == 0) return 1;
      if (v > lim) return lim;
      return v;
    endfunction

    function void apply_reg(logic [r2n_pkg::CFG_IDX_W-1:0] idx,
                            logic [r2n_pkg::CFG_W-1:0] val);
      if (idx == r2n_pkg::REG_FRAME_WIDTH) width_reg = val;
      else if (idx == r2n_pkg::REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    function void note_pixel(r2n_pkg::pixel_t px);
      int               r, g, b, w, h, y, cb, cr, pcb, pcr, scb, scr, idx;
      bit               last_col, last_row;
      r2n_pkg::result_t want;
      r = int'(px.red);
      g = int'(px.green);
      b = int'(px.blue);
      w = clamp_size(int'(width_reg), r2n_pkg::MAX_WIDTH);
      h = clamp_size(int'(height_reg), r2n_pkg::MAX_HEIGHT);
      last_col = (col_cnt >= w - 1);
      last_row = (row_cnt >= h - 1);
      y  = ((r2n_pkg::Y_R * r + r2n_pkg::Y_G * g + r2n_pkg::Y_B * b + r2n_pkg::ROUND) >> 8)
           + r2n_pkg::Y_OFS;
      cb = (r2n_pkg::C_OFS + r2n_pkg::CB_B * b - r2n_pkg::CB_R * r - r2n_pkg::CB_G * g) >> 8;
      cr = (r2n_pkg::C_OFS + r2n_pkg::CR_R * r - r2n_pkg::CR_G * g - r2n_pkg::CR_B * b) >> 8;
      want = '0;
      want.luma = y[7:0];
      if (col_cnt % 2 == 0 && !last_col) begin
        left_cb = cb[7:0];
        left_cr = cr[7:0];
      end else begin
        idx = col_cnt / 2;
        if (col_cnt % 2 == 1) begin
          pcb = int'(left_cb) + cb;
          pcr = int'(left_cr) + cr;
        end else begin
          // block ends on an even last column: that pixel counts twice
          pcb = 2 * cb;
          pcr = 2 * cr;
        end
        if (row_cnt % 2 == 0 && !last_row) begin
          pair_sums[idx] = {pcb[8:0], pcr[8:0]};
        end else begin
          if (row_cnt % 2 == 1) begin
            scb = int'(pair_sums[idx][17:9]) + pcb;
            scr = int'(pair_sums[idx][8:0]) + pcr;
          end else begin
            // even last row closes its own blocks
            scb = 2 * pcb;
            scr = 2 * pcr;
          end
          want.chroma_valid = 1'b1;
          want.cb_value     = scb[9:2];
          want.cr_value     = scr[9:2];
        end
      end
      if (last_col) begin
        col_cnt = 0;
        if (last_row) begin
          row_cnt = 0;
          want.frame_done = 1'b1;
        end else begin
          row_cnt++;
        end
      end else begin
        col_cnt++;
      end
      pending_yuv.push_back(want);
    endfunction

    function void check_result(r2n_pkg::result_t got);
      r2n_pkg::result_t want;
      if (pending_yuv.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected result luma=%0d cv=%0d cb=%0d cr=%0d done=%0d",
                   $time, got.luma, got.chroma_valid, got.cb_value, got.cr_value,
                   got.frame_done);
        return;
      end
      want = pending_yuv.pop_front();
      if (got.luma !== want.luma || got.chroma_valid !== want.chroma_valid ||
          got.cb_value !== want.cb_value || got.cr_value !== want.cr_value ||
          got.frame_done !== want.frame_done) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: result mismatch: expected luma=%0d cv=%0d cb=%0d cr=%0d done=%0d",
                    ", got luma=%0d cv=%0d cb=%0d cr=%0d done=%0d"},
                   $time, want.luma, want.chroma_valid, want.cb_value, want.cr_value,
                   want.frame_done, got.luma, got.chroma_valid, got.cb_value,
                   got.cr_value, got.frame_done);
      end
    endfunction
  endclass

  // Every input starts at a known value
  logic                          clk;
  logic                          rst          = 1'b1;
  logic                          pixel_valid  = 1'b0;
  r2n_pkg::pixel_t               pixel        = '0;
  logic                          result_ready = 1'b0;
  logic                          cfg_valid    = 1'b0;
  logic [r2n_pkg::CFG_IDX_W-1:0] cfg_index    = '0;
  logic [r2n_pkg::CFG_W-1:0]     cfg_data     = '0;
  logic                          pixel_ready;
  logic                          result_valid;
  logic                          cfg_ready;
  r2n_pkg::result_t              result;

  // Idle odds in percent; the main sequence moves them through three regimes
  int src_idle_pct = 24;
  int snk_idle_pct = 73;
  int sent         = 0;

  nv12_predictor yuv_model;

  rgb_to_nv12_converter_core DUT (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_ready  (pixel_ready),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Sink side: ready drops at random, redrawn every falling edge
  always @(negedge clk) begin
    result_ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Every handshaked result is checked against the oldest prediction
  always @(posedge clk) begin
    if (!rst && result_valid && result_ready) yuv_model.check_result(result);
  end

  // Hard stop well past the slowest legal run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic r2n_pkg::pixel_t mk_pixel(int r, int g, int b);
    r2n_pkg::pixel_t px;
    px.red   = 8'(r);
    px.green = 8'(g);
    px.blue  = 8'(b);
    return px;
  endfunction

  // Components lean toward black and full scale
  function automatic logic [7:0] rand_level();
    case ($urandom_range(7))
      0: begin
        return 8'h00;
      end
      1: begin
        return 8'hFF;
      end
      default: begin
        return 8'($urandom);
      end
    endcase
  endfunction

  function automatic r2n_pkg::pixel_t rand_pixel();
    return mk_pixel(rand_level(), rand_level(), rand_level());
  endfunction

  // Mostly tiny frames so many blocks and frame ends come by; sometimes
  // zero, the maximum, or beyond it
  function automatic logic [r2n_pkg::CFG_W-1:0] pick_size();
    case ($urandom_range(15))
      0: begin
        return '0;
      end
      1: begin
        return '1;
      end
      2: begin
        return r2n_pkg::CFG_W'(r2n_pkg::MAX_WIDTH);
      end
      3: begin
        return r2n_pkg::CFG_W'($urandom_range(8191, r2n_pkg::MAX_WIDTH + 1));
      end
      default: begin
        return r2n_pkg::CFG_W'($urandom_range(12, 1));
      end
    endcase
  endfunction

  // A whole frame when it is small, else a short run of pixels;
  // frames carry over from one phase to the next
  function automatic int phase_len();
    int w, h;
    w = nv12_predictor::clamp_size(int'(yuv_model.width_reg), r2n_pkg::MAX_WIDTH);
    h = nv12_predictor::clamp_size(int'(yuv_model.height_reg), r2n_pkg::MAX_HEIGHT);
    if (w * h <= 64 && $urandom_range(3) != 0) return w * h;
    return $urandom_range(40, 1);
  endfunction

  // Called at a falling edge, returns at a falling edge with valid still high
  task automatic send_pixel(input r2n_pkg::pixel_t px);
    while ($urandom_range(99) < src_idle_pct) begin
      pixel_valid <= 1'b0;
      @(negedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do @(posedge clk); while (!pixel_ready);
    yuv_model.note_pixel(px);
    sent++;
    @(negedge clk);
  endtask

  // One register write request; leaves a cycle with valid low behind it
  task automatic cfg_write(input logic [r2n_pkg::CFG_IDX_W-1:0] idx,
                           input logic [r2n_pkg::CFG_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    yuv_model.apply_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Sender holds off until all predicted results are out; every
  // pixel yields a result, so an empty queue means the pipe is empty
  task automatic drain_all();
    while (yuv_model.pending_yuv.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_phase(input int n);
    repeat (n) send_pixel(rand_pixel());
    pixel_valid <= 1'b0;
  endtask

  // New frame size, often mid-frame. Changes are held back where they
  // would make an odd row read line-store entries its even row never wrote.
  task automatic retune_frame();
    logic [r2n_pkg::CFG_W-1:0] w, h;
    w = pick_size();
    h = pick_size();
    // odd row pairs with the sums of the even row above: width stays
    if (yuv_model.row_cnt % 2 == 1) w = yuv_model.width_reg;
    // part of an even row done: its last-row status must not flip
    else if (yuv_model.col_cnt != 0) h = yuv_model.height_reg;
    if ($urandom_range(5) == 0)
      cfg_write($urandom_range(1) ? REG_SPARE_3 : REG_SPARE_2, r2n_pkg::CFG_W'($urandom));
    if ($urandom_range(1)) begin
      cfg_write(r2n_pkg::REG_FRAME_WIDTH, w);
      cfg_write(r2n_pkg::REG_FRAME_HEIGHT, h);
    end else begin
      cfg_write(r2n_pkg::REG_FRAME_HEIGHT, h);
      cfg_write(r2n_pkg::REG_FRAME_WIDTH, w);
    end
  endtask

  initial begin
    int drain;
    yuv_model = new();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // 2x2 frame: black, white, full red, full green close one block
    cfg_write(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::CFG_W'(2));
    cfg_write(r2n_pkg::REG_FRAME_HEIGHT, r2n_pkg::CFG_W'(2));
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(255, 0, 0));
    send_pixel(mk_pixel(0, 255, 0));
    pixel_valid <= 1'b0;
    drain_all();

    // 3x3 frame: odd width doubles the last column, odd height the last row
    cfg_write(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::CFG_W'(3));
    cfg_write(r2n_pkg::REG_FRAME_HEIGHT, r2n_pkg::CFG_W'(3));
    send_pixel(mk_pixel(0, 0, 255));
    send_pixel(mk_pixel(255, 255, 0));
    send_pixel(mk_pixel(0, 255, 255));
    send_pixel(mk_pixel(255, 0, 255));
    send_pixel(mk_pixel(128, 128, 128));
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(0, 0, 0));
    send_pixel(mk_pixel(255, 0, 0));
    send_pixel(mk_pixel(0, 0, 255));
    pixel_valid <= 1'b0;
    drain_all();

    // zero sizes act as 1x1: every pixel is a whole frame
    cfg_write(r2n_pkg::REG_FRAME_WIDTH, '0);
    cfg_write(r2n_pkg::REG_FRAME_HEIGHT, '0);
    send_pixel(mk_pixel(255, 255, 255));
    send_pixel(mk_pixel(0, 0, 0));
    pixel_valid <= 1'b0;
    drain_all();

    // oversize acts as the maximum; then shrink width mid-row so the
    // column already passed counts as the last one
    cfg_write(r2n_pkg::REG_FRAME_WIDTH, '1);
    cfg_write(r2n_pkg::REG_FRAME_HEIGHT, '1);
    run_phase(3);
    drain_all();
    cfg_write(r2n_pkg::REG_FRAME_WIDTH, r2n_pkg::CFG_W'(2));
    run_phase(2);
    drain_all();

    // Random phases: sender mostly busy / sink stalling, then swapped,
    // then both at full rate
    while (sent < DIRECTED_PIXELS + RANDOM_PIXELS) begin
      if (sent >= DIRECTED_PIXELS + 2 * RANDOM_PIXELS / 3) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (sent >= DIRECTED_PIXELS + RANDOM_PIXELS / 3) begin
        src_idle_pct = 73;
        snk_idle_pct = 24;
      end
      retune_frame();
      run_phase(phase_len());
      drain_all();
    end

    drain = 0;
    while (yuv_model.pending_yuv.size() != 0 && drain < 10000) begin
      @(negedge clk);
      drain++;
    end
    repeat (10) @(negedge clk);
    if (yuv_model.mismatches == 0 && yuv_model.pending_yuv.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
design/r2n_pkg.sv
design/rgb_to_nv12_converter_core.sv
bench/rgb_to_nv12_converter_core_tb.sv
